// ===== design/ptrs_pkg.sv =====
// Shared constants, codes and control types of the periodic task release scheduler.
`timescale 1ns / 1ps
`default_nettype none
package ptrs_pkg;

  localparam int NUM_TASKS_DEF = 8;
  localparam int MAX_RESULTS   = 8;
  localparam int MODE_W        = 3;
  localparam int IDX_W         = 3;
  localparam int TICK_W        = 16;
  localparam int DELAY_W       = 8;
  localparam int NREP_W        = $clog2(MAX_RESULTS + 1);

  localparam logic [MODE_W-1:0] MODE_TICK    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CREATE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SUSPEND = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RESUME  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DELETE  = 3'd4;

  typedef enum logic [1:0] {
    TS_DORMANT   = 2'd0,
    TS_READY     = 2'd1,
    TS_SUSPENDED = 2'd2
  } task_st_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMD,
    S_T_INC,
    S_T_READ,
    S_T_EVAL,
    S_T_DIV,
    S_T_FIRE,
    S_T_END
  } ctrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic tick_inc;
    logic cmd_apply;
    logic div_start;
    logic slot_dec;
    logic slot_fire;
    logic slot_next;
    logic emit_end;
  } ptrs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic req_tick;
    logic cand;
    logic div_busy;
    logic due;
    logic last_slot;
    logic out_free;
    logic fire_block;
  } ptrs_stat_t;

endpackage
`default_nettype wire

// ===== design/ptrs_moddiv.sv =====
// Iterative remainder unit, two dividend bits per cycle, reports a zero remainder.
`timescale 1ns / 1ps
`default_nettype none
module ptrs_moddiv import ptrs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [TICK_W-1:0] dividend,
  input  wire logic [TICK_W-1:0] divisor,
  output logic                   busy,
  output logic                   rem_zero
);

  localparam int DIV_STEPS = TICK_W / 2;
  localparam int CNT_W     = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  logic [TICK_W-1:0] rem;
  logic [TICK_W-1:0] dq;
  logic [CNT_W-1:0]  cnt;
  logic [TICK_W-1:0] rem_a;
  logic [TICK_W-1:0] rem_b;

  function automatic logic [TICK_W-1:0] rem_step(input logic [TICK_W-1:0] r,
                                                 input logic b,
                                                 input logic [TICK_W-1:0] d);
    logic [TICK_W:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[TICK_W-1:0];
  endfunction

  always_comb begin
    rem_a = rem_step(rem, dq[TICK_W-1], divisor);
    rem_b = rem_step(rem_a, dq[TICK_W-2], divisor);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && (cnt == CNT_LAST)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dq  <= dividend;
      cnt <= '0;
    end else if (busy) begin
      rem <= rem_b;
      dq  <= {dq[TICK_W-3:0], 2'b00};
      cnt <= cnt + 1'b1;
    end
  end

  assign rem_zero = (rem == '0);

endmodule
`default_nettype wire

// ===== design/ptrs_datapath.sv =====
// Task table, tick count, remainder unit, pending fire and result register.
`timescale 1ns / 1ps
`default_nettype none
module ptrs_datapath import ptrs_pkg::*; #(
  parameter int NUM_TASKS = NUM_TASKS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ptrs_cmd_t          cmd,
  output ptrs_stat_t              stat,
  input  wire logic [MODE_W-1:0]  mode,
  input  wire logic [IDX_W-1:0]   task_index,
  input  wire logic [TICK_W-1:0]  period_ticks,
  input  wire logic [DELAY_W-1:0] first_delay,
  output logic                    res_valid,
  input  wire logic               res_stall,
  output logic [IDX_W-1:0]        fired_index,
  output logic                    fired,
  output logic                    status,
  output logic                    last
);

  localparam int SW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam logic [SW-1:0] SLOT_LAST = SW'(NUM_TASKS - 1);

  // period and delay are always written by create before a slot turns ready
  logic [TICK_W-1:0]  per_mem [NUM_TASKS];
  logic [DELAY_W-1:0] dly_mem [NUM_TASKS];
  task_st_t           task_st [NUM_TASKS];

  logic [TICK_W-1:0]  per_rd;
  logic [DELAY_W-1:0] dly_rd;

  logic [TICK_W-1:0]  tick_count;
  logic [SW-1:0]      slot;
  logic [MODE_W-1:0]  mode_q;
  logic               idx_ok;
  logic [TICK_W-1:0]  per_in;
  logic [DELAY_W-1:0] dly_in;
  logic               pend_valid;
  logic [IDX_W-1:0]   pend_idx;
  logic [NREP_W-1:0]  nrep;

  logic               div_busy;
  logic               rem_zero;

  task_st_t           st_cur;
  logic               cmd_ok;
  task_st_t           st_new;
  logic               report;
  logic               out_free;

  logic               per_we;
  logic [TICK_W-1:0]  per_wdata;
  logic               dly_we;
  logic [DELAY_W-1:0] dly_wdata;

  logic               out_load;
  logic [IDX_W-1:0]   out_idx;
  logic               out_fired;
  logic               out_status;
  logic               out_last;

  ptrs_moddiv u_moddiv (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (tick_count),
    .divisor  (per_rd),
    .busy     (div_busy),
    .rem_zero (rem_zero)
  );

  assign st_cur   = task_st[slot];
  assign report   = (nrep < NREP_W'(MAX_RESULTS));
  assign out_free = !res_valid || !res_stall;

  always_comb begin
    cmd_ok = 1'b0;
    st_new = st_cur;
    case (mode_q)
      MODE_CREATE: begin
        cmd_ok = idx_ok;
        st_new = TS_READY;
      end
      MODE_SUSPEND: begin
        cmd_ok = idx_ok && (st_cur == TS_READY);
        st_new = TS_SUSPENDED;
      end
      MODE_RESUME: begin
        cmd_ok = idx_ok && (st_cur != TS_DORMANT);
        st_new = TS_READY;
      end
      MODE_DELETE: begin
        cmd_ok = idx_ok && (st_cur != TS_DORMANT);
        st_new = TS_DORMANT;
      end
      default: begin
        cmd_ok = 1'b0;
      end
    endcase
  end

  // table write ports
  always_comb begin
    per_we    = cmd.cmd_apply && cmd_ok && (mode_q == MODE_CREATE);
    per_wdata = per_in;
    dly_we    = 1'b0;
    dly_wdata = dly_rd - 1'b1;
    if (cmd.cmd_apply && cmd_ok && (mode_q == MODE_CREATE)) begin
      dly_we    = 1'b1;
      dly_wdata = dly_in;
    end else if (cmd.slot_fire) begin
      dly_we    = 1'b1;
      dly_wdata = per_rd[DELAY_W-1:0] - 1'b1;
    end else if (cmd.slot_dec) begin
      dly_we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (per_we) begin
      per_mem[slot] <= per_wdata;
    end
    per_rd <= per_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (dly_we) begin
      dly_mem[slot] <= dly_wdata;
    end
    dly_rd <= dly_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        task_st[i] <= TS_DORMANT;
      end
    end else if (cmd.cmd_apply && cmd_ok) begin
      task_st[slot] <= st_new;
    end
  end

  // item capture and walk position
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q <= mode;
      idx_ok <= (int'(task_index) < NUM_TASKS);
      slot   <= SW'(task_index);
      per_in <= period_ticks;
      dly_in <= first_delay;
    end else if (cmd.tick_inc) begin
      slot <= '0;
    end else if (cmd.slot_next) begin
      slot <= slot + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
    end else if (cmd.tick_inc) begin
      tick_count <= tick_count + 1'b1;
    end
  end

  // last reported fire is held back until the walk knows whether another follows
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      nrep       <= '0;
    end else if (cmd.tick_inc) begin
      pend_valid <= 1'b0;
      nrep       <= '0;
    end else if (cmd.slot_fire && report) begin
      pend_valid <= 1'b1;
      nrep       <= nrep + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.slot_fire && report) begin
      pend_idx <= IDX_W'(slot);
    end
  end

  always_comb begin
    out_load   = 1'b0;
    out_idx    = '0;
    out_fired  = 1'b0;
    out_status = 1'b0;
    out_last   = 1'b1;
    if (cmd.cmd_apply) begin
      out_load   = 1'b1;
      out_status = !cmd_ok;
    end else if (cmd.slot_fire && report && pend_valid) begin
      out_load  = 1'b1;
      out_idx   = pend_idx;
      out_fired = 1'b1;
      out_last  = 1'b0;
    end else if (cmd.emit_end) begin
      out_load = 1'b1;
      if (pend_valid) begin
        out_idx   = pend_idx;
        out_fired = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      fired_index <= out_idx;
      fired       <= out_fired;
      status      <= out_status;
      last        <= out_last;
    end
  end

  always_comb begin
    stat.req_tick   = (mode == MODE_TICK);
    stat.cand       = (st_cur == TS_READY) && (per_rd != '0) && (dly_rd == '0);
    stat.div_busy   = div_busy;
    stat.due        = rem_zero;
    stat.last_slot  = (slot == SLOT_LAST);
    stat.out_free   = out_free;
    stat.fire_block = report && pend_valid && !out_free;
  end

endmodule
`default_nettype wire

// ===== design/ptrs_ctrl.sv =====
// Controller state machine: command execution and the tick walk over the task slots.
`timescale 1ns / 1ps
`default_nettype none
module ptrs_ctrl import ptrs_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_ready,
  input  wire ptrs_stat_t stat,
  output ptrs_cmd_t       cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = stat.req_tick ? S_T_INC : S_CMD;
        end
      end
      S_CMD: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      S_T_INC: begin
        state_next = S_T_READ;
      end
      S_T_READ: begin
        state_next = S_T_EVAL;
      end
      S_T_EVAL: begin
        if (stat.cand) begin
          state_next = S_T_DIV;
        end else begin
          state_next = stat.last_slot ? S_T_END : S_T_READ;
        end
      end
      S_T_DIV: begin
        if (!stat.div_busy) begin
          if (stat.due) begin
            state_next = S_T_FIRE;
          end else begin
            state_next = stat.last_slot ? S_T_END : S_T_READ;
          end
        end
      end
      S_T_FIRE: begin
        if (!stat.fire_block) begin
          state_next = stat.last_slot ? S_T_END : S_T_READ;
        end
      end
      S_T_END: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
      end
      S_CMD: begin
        cmd.cmd_apply = stat.out_free;
      end
      S_T_INC: begin
        cmd.tick_inc = 1'b1;
      end
      S_T_EVAL: begin
        if (stat.cand) begin
          cmd.div_start = 1'b1;
        end else begin
          cmd.slot_dec  = 1'b1;
          cmd.slot_next = !stat.last_slot;
        end
      end
      S_T_DIV: begin
        if (!stat.div_busy && !stat.due) begin
          cmd.slot_dec  = 1'b1;
          cmd.slot_next = !stat.last_slot;
        end
      end
      S_T_FIRE: begin
        if (!stat.fire_block) begin
          cmd.slot_fire = 1'b1;
          cmd.slot_next = !stat.last_slot;
        end
      end
      S_T_END: begin
        cmd.emit_end = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== design/periodic_task_release_scheduler_core.sv =====
// Top level of the periodic task release scheduler: controller plus datapath.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+------------------------------------------------
//  request | req_valid | req_stall | mode, task_index, period_ticks, first_delay
//  result  | res_valid | res_stall | fired_index, fired, status, last
//
// One item at a time.
// A tick walks every slot in turn and runs the remainder unit for every ready slot with a nonzero
// period and a zero delay (the remainder unit resolves two count bits per cycle).
// Reset clears the tick count and sets every slot dormant.
// A stalled result register holds the walk only when a further result must leave.
`timescale 1ns / 1ps
`default_nettype none
module periodic_task_release_scheduler_core import ptrs_pkg::*; #(
  parameter int NUM_TASKS = NUM_TASKS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire logic [MODE_W-1:0]  mode,
  input  wire logic [IDX_W-1:0]   task_index,
  input  wire logic [TICK_W-1:0]  period_ticks,
  input  wire logic [DELAY_W-1:0] first_delay,
  output logic                    res_valid,
  input  wire logic               res_stall,
  output logic [IDX_W-1:0]        fired_index,
  output logic                    fired,
  output logic                    status,
  output logic                    last
);

  ptrs_cmd_t  cmd;
  ptrs_stat_t stat;
  logic       req_ready;

  assign req_stall = !req_ready;

  ptrs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ptrs_datapath #(
    .NUM_TASKS (NUM_TASKS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .mode         (mode),
    .task_index   (task_index),
    .period_ticks (period_ticks),
    .first_delay  (first_delay),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .fired_index  (fired_index),
    .fired        (fired),
    .status       (status),
    .last         (last)
  );

endmodule
`default_nettype wire

// ===== design/ptrs_checker.sv =====
// Port-level checks of the scheduler core, attached by bind.
`timescale 1ns / 1ps
`default_nettype none
module ptrs_checker import ptrs_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               req_valid,
  input wire logic               req_stall,
  input wire logic               res_valid,
  input wire logic               res_stall,
  input wire logic [IDX_W-1:0]   fired_index,
  input wire logic               fired,
  input wire logic               status,
  input wire logic               last
);

  // nothing leaves straight out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid in the cycle after reset");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(fired_index) && $stable(fired)
                               && $stable(status) && $stable(last))
    else $error("stalled result changed or dropped");

  // a request transfer always leaves the idle state
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second request taken in back-to-back cycles");

  a_nofire_idx: assert property (@(posedge clk) disable iff (rst)
    res_valid && !fired |-> fired_index == '0 && last)
    else $error("non-fire result with slot or not final");

  a_fire_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && fired |-> !status)
    else $error("fire result reports refusal");

endmodule

bind periodic_task_release_scheduler_core ptrs_checker u_ptrs_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req_valid),
  .req_stall   (req_stall),
  .res_valid   (res_valid),
  .res_stall   (res_stall),
  .fired_index (fired_index),
  .fired       (fired),
  .status      (status),
  .last        (last)
);
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the periodic task release scheduler core.
`timescale 1ns / 1ps
module tb;
  import ptrs_pkg::*;

  localparam int NUM_TASKS    = NUM_TASKS_DEF;
  localparam int RANDOM_ITEMS = 480;
  localparam int DRAIN_CYCLES = 120;
  localparam int STALL_LIMIT  = 4000;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic             fired;
    logic             status;
    logic             last;
  } release_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_stall;
  logic [MODE_W-1:0]   mode = MODE_TICK;
  logic [IDX_W-1:0]    task_index = '0;
  logic [TICK_W-1:0]   period_ticks = '0;
  logic [DELAY_W-1:0]  first_delay = '0;
  logic                res_valid;
  logic                res_stall = 1'b0;
  logic [IDX_W-1:0]    fired_index;
  logic                fired;
  logic                status;
  logic                last;

  // predicted scheduler state
  logic [TICK_W-1:0]   tick_cnt;
  logic [TICK_W-1:0]   slot_period [NUM_TASKS];
  logic [DELAY_W-1:0]  slot_delay [NUM_TASKS];
  task_st_t            slot_state [NUM_TASKS];

  release_t            pending_releases [$];
  release_t            want;
  int                  errors = 0;
  bit                  quiet = 1'b0;

  periodic_task_release_scheduler_core uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) res_stall <= !quiet && ($urandom_range(99) < 18);

  task automatic flag_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    errors++;
  endtask

  // Applies one accepted request to the predicted table and queues its results.
  task automatic advance_schedule(input logic [MODE_W-1:0] m, input logic [IDX_W-1:0] idx,
                                  input logic [TICK_W-1:0] p, input logic [DELAY_W-1:0] d);
    int       hits [$];
    release_t r;
    if (m == MODE_TICK) begin
      tick_cnt = tick_cnt + 1'b1;
      for (int i = 0; i < NUM_TASKS; i++) begin
        if (slot_period[i] != 0 && tick_cnt % slot_period[i] == 0 &&
            slot_state[i] == TS_READY && slot_delay[i] == 0) begin
          slot_delay[i] = DELAY_W'(slot_period[i] - 1'b1);
          if (hits.size() < MAX_RESULTS) hits.push_back(i);
        end else begin
          slot_delay[i] = slot_delay[i] - 1'b1;
        end
      end
      if (hits.size() == 0) begin
        r = '{idx: '0, fired: 1'b0, status: 1'b0, last: 1'b1};
        pending_releases.push_back(r);
      end
      foreach (hits[k]) begin
        r = '{idx: IDX_W'(hits[k]), fired: 1'b1, status: 1'b0,
              last: (k == hits.size() - 1)};
        pending_releases.push_back(r);
      end
    end else begin
      r = '{idx: '0, fired: 1'b0, status: 1'b1, last: 1'b1};
      if (idx < NUM_TASKS) begin
        case (m)
          MODE_CREATE: begin
            slot_period[idx] = p;
            slot_delay[idx]  = d;
            slot_state[idx]  = TS_READY;
            r.status = 1'b0;
          end
          MODE_SUSPEND: if (slot_state[idx] == TS_READY) begin
            slot_state[idx] = TS_SUSPENDED;
            r.status = 1'b0;
          end
          MODE_RESUME: if (slot_state[idx] != TS_DORMANT) begin
            slot_state[idx] = TS_READY;
            r.status = 1'b0;
          end
          MODE_DELETE: if (slot_state[idx] != TS_DORMANT) begin
            slot_state[idx] = TS_DORMANT;
            r.status = 1'b0;
          end
          default: ;
        endcase
      end
      pending_releases.push_back(r);
    end
  endtask

  task automatic issue_request(input logic [MODE_W-1:0] m, input logic [IDX_W-1:0] idx,
                               input logic [TICK_W-1:0] p, input logic [DELAY_W-1:0] d);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 18) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid    <= 1'b1;
    mode         <= m;
    task_index   <= idx;
    period_ticks <= p;
    first_delay  <= d;
    do @(posedge clk); while (req_stall);
    advance_schedule(m, idx, p, d);
  endtask

  // commands on an empty table, unknown modes, a tick that releases nothing
  task automatic test_dormant_slots();
    issue_request(MODE_TICK, 3'd0, 16'd0, 8'd0);
    issue_request(MODE_SUSPEND, 3'd2, 16'hFFFF, 8'hFF);
    issue_request(MODE_RESUME, 3'd5, 16'd0, 8'd0);
    issue_request(MODE_DELETE, 3'd7, 16'd0, 8'd0);
    for (int k = 1; k <= 3; k++)
      issue_request(MODE_DELETE + MODE_W'(k), 3'd1, 16'd1, 8'd0);
  endtask

  // every slot due on the same tick: the widest burst of transfers
  task automatic test_all_slots_release();
    for (int i = 0; i < NUM_TASKS; i++)
      issue_request(MODE_CREATE, IDX_W'(i), 16'd1, 8'd0);
    issue_request(MODE_TICK, 3'd0, 16'd0, 8'd0);
  endtask

  task automatic test_slot_lifecycle();
    issue_request(MODE_CREATE, 3'd0, 16'd0, 8'd0);       // zero period, never due
    issue_request(MODE_CREATE, 3'd7, 16'hFFFF, 8'hFF);
    issue_request(MODE_SUSPEND, 3'd1, 16'd0, 8'd0);
    issue_request(MODE_SUSPEND, 3'd1, 16'd0, 8'd0);      // already suspended
    issue_request(MODE_RESUME, 3'd1, 16'd0, 8'd0);
    issue_request(MODE_RESUME, 3'd2, 16'd0, 8'd0);       // resume while ready
    issue_request(MODE_DELETE, 3'd3, 16'd0, 8'd0);
    issue_request(MODE_DELETE, 3'd3, 16'd0, 8'd0);
    issue_request(MODE_RESUME, 3'd3, 16'd0, 8'd0);
    issue_request(MODE_TICK, 3'd0, 16'd0, 8'd0);
  endtask

  task automatic test_random_traffic();
    int                 pick;
    logic [MODE_W-1:0]  m;
    logic [IDX_W-1:0]   idx;
    logic [TICK_W-1:0]  p;
    logic [DELAY_W-1:0] d;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= 200 && n < 300);
      pick  = $urandom_range(99);
      idx   = IDX_W'($urandom_range(NUM_TASKS - 1));
      p     = TICK_W'($urandom);
      d     = DELAY_W'($urandom);
      if (pick < 45) begin
        m = MODE_TICK;
      end else if (pick < 65) begin
        // delay chosen so the first release lands on a multiple of the period
        m = MODE_CREATE;
        p = ($urandom_range(9) == 0) ? TICK_W'($urandom_range(1, 256))
                                     : TICK_W'($urandom_range(1, 12));
        d = DELAY_W'(p - 1'b1 - tick_cnt % p);
      end else if (pick < 75) begin
        m = MODE_CREATE;
        if ($urandom_range(7) == 0) p = '0;
      end else if (pick < 83) begin
        m = MODE_SUSPEND;
      end else if (pick < 91) begin
        m = MODE_RESUME;
      end else if (pick < 97) begin
        m = MODE_DELETE;
      end else begin
        m = MODE_DELETE + MODE_W'($urandom_range(1, 3));
      end
      issue_request(m, idx, p, d);
    end
    quiet = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (pending_releases.size() == 0) begin
        flag_mismatch("result transfer with nothing expected");
      end else begin
        want = pending_releases.pop_front();
        if (fired_index !== want.idx)
          flag_mismatch($sformatf("fired_index %0d, expected %0d", fired_index, want.idx));
        if (fired !== want.fired)
          flag_mismatch($sformatf("fired %0b, expected %0b", fired, want.fired));
        if (status !== want.status)
          flag_mismatch($sformatf("status %0b, expected %0b", status, want.status));
        if (last !== want.last)
          flag_mismatch($sformatf("last %0b, expected %0b", last, want.last));
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (res_valid && !res_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    tick_cnt = '0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      slot_period[i] = '0;
      slot_delay[i]  = '0;
      slot_state[i]  = TS_DORMANT;
    end
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    test_dormant_slots();
    test_all_slots_release();
    test_slot_lifecycle();
    test_random_traffic();
    @(negedge clk) req_valid <= 1'b0;
    while (pending_releases.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
